/* sv/lrbc_pkg.sv */
// Package for the link reconnect backoff controller.
// It holds the register reset values, the register indexes and the event and status codes.
// It depends on nothing else.
`default_nettype none

package lrbc_pkg;

  localparam int unsigned RegWidth  = 16;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [RegWidth-1:0] TimeoutRst    = 16'd15000;
  localparam logic [RegWidth-1:0] BackoffMinRst = 16'd1000;
  localparam logic [RegWidth-1:0] BackoffMaxRst = 16'd30000;

  localparam logic [CfgIdxW-1:0] RegAttemptTimeout = 2'd0;
  localparam logic [CfgIdxW-1:0] RegBackoffMin     = 2'd1;
  localparam logic [CfgIdxW-1:0] RegBackoffMax     = 2'd2;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_CONNECTED    = 3'd1,
    EV_RECONNECTED  = 3'd2,
    EV_DISCONNECTED = 3'd3,
    EV_TIMEOUT      = 3'd4
  } event_t;

  typedef enum logic [1:0] {
    ST_CONNECTED  = 2'd0,
    ST_CONNECTING = 2'd1,
    ST_DOWN       = 2'd2
  } status_t;

endpackage

`default_nettype wire

/* sv/link_reconnect_backoff_controller.sv */
// Top level of the link reconnect backoff controller.
// It holds the tick input register, the supervisor state update and the result register.
// It depends on lrbc_pkg.
`default_nettype none

// The block supervises a link connection with exponential retry backoff. Each input item
// is one tick that carries the link's association flag, and each tick yields exactly one
// result item: start_attempt, link_up, status and event. The block processes one item
// every clock cycle unless the result side stalls. An accepted item sits in an input
// register, runs from there through the state update, and is written into the result
// register once that register is free or its result is being taken. The single update
// pass per cycle between these two registers sets this rate. The result register holds
// a result until it is taken, and the input register keeps taking items while the result
// register drains, so the input stalls only when both registers are full. Configuration
// registers are written through cfg_we, cfg_index and cfg_data and take effect with the
// next processed tick; index 0 is the attempt timeout, 1 the minimum backoff, 2 the
// maximum backoff, and any other index is ignored. The doubled retry delay saturates at
// the maximum backoff, and a timeout of 65535 means an attempt never times out.
module link_reconnect_backoff_controller
  import lrbc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // Tick input. s_tdata fields from bit 0 up: associated[0], zero fill [7:1].
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [7:0]          s_tdata,
  // Result output. m_tdata fields from bit 0 up: start_attempt[0], link_up[1],
  // status[3:2], event_res[6:4], zero fill [7].
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [7:0]               m_tdata,
  // Configuration write port.
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [RegWidth-1:0] cfg_data
);

  // Configuration registers.
  logic [RegWidth-1:0] attempt_timeout;
  logic [RegWidth-1:0] backoff_min;
  logic [RegWidth-1:0] backoff_max;

  // Supervisor state.
  logic                connected_flag;
  logic                ever_connected;
  logic [RegWidth-1:0] attempt_ticks;
  logic                retry_pending;
  logic [RegWidth-1:0] retry_ticks_left;
  logic [RegWidth-1:0] current_backoff;

  logic                connected_flag_next;
  logic                ever_connected_next;
  logic [RegWidth-1:0] attempt_ticks_next;
  logic                retry_pending_next;
  logic [RegWidth-1:0] retry_ticks_left_next;
  logic [RegWidth-1:0] current_backoff_next;

  // Input register and result register.
  logic       in_valid;
  logic       in_assoc;
  logic       out_valid;
  logic [6:0] out_data;

  logic       advance;
  logic       start_next;
  event_t     event_next;
  status_t    status_next;
  logic [RegWidth:0]   doubled;
  logic [RegWidth-1:0] clamped;
  logic [RegWidth-1:0] ticks_inc;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_data};

  // Doubling of the retry delay, saturating at the configured maximum.
  assign doubled = {current_backoff, 1'b0};
  assign clamped = (doubled < {1'b0, backoff_max}) ? doubled[RegWidth-1:0] : backoff_max;
  assign ticks_inc = (attempt_ticks != {RegWidth{1'b1}}) ? attempt_ticks + 1'b1
                                                          : attempt_ticks;

  always_comb begin
    connected_flag_next   = connected_flag;
    ever_connected_next   = ever_connected;
    attempt_ticks_next    = attempt_ticks;
    retry_pending_next    = retry_pending;
    retry_ticks_left_next = retry_ticks_left;
    current_backoff_next  = current_backoff;
    start_next            = 1'b0;
    event_next            = EV_NONE;

    if (in_assoc) begin
      // A new association drops any pending retry and restores the minimum delay.
      if (!connected_flag) begin
        event_next            = ever_connected ? EV_RECONNECTED : EV_CONNECTED;
        ever_connected_next   = 1'b1;
        connected_flag_next   = 1'b1;
        current_backoff_next  = backoff_min;
        retry_pending_next    = 1'b0;
        retry_ticks_left_next = '0;
      end
    end else if (connected_flag) begin
      event_next            = EV_DISCONNECTED;
      connected_flag_next   = 1'b0;
      retry_pending_next    = 1'b1;
      retry_ticks_left_next = current_backoff;
      current_backoff_next  = clamped;
    end else if (retry_pending) begin
      // A delay of zero or one comes due on this tick.
      if (retry_ticks_left <= RegWidth'(1)) begin
        retry_pending_next    = 1'b0;
        retry_ticks_left_next = '0;
        attempt_ticks_next    = '0;
        start_next            = 1'b1;
      end else begin
        retry_ticks_left_next = retry_ticks_left - 1'b1;
      end
    end else begin
      attempt_ticks_next = ticks_inc;
      if (ticks_inc > attempt_timeout) begin
        event_next            = EV_TIMEOUT;
        retry_pending_next    = 1'b1;
        retry_ticks_left_next = current_backoff;
        current_backoff_next  = clamped;
      end
    end

    if (connected_flag_next) begin
      status_next = ST_CONNECTED;
    end else if (retry_pending_next) begin
      status_next = ST_DOWN;
    end else begin
      status_next = ST_CONNECTING;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attempt_timeout <= TimeoutRst;
      backoff_min     <= BackoffMinRst;
      backoff_max     <= BackoffMaxRst;
    end else if (cfg_we) begin
      case (cfg_index)
        RegAttemptTimeout: attempt_timeout <= cfg_data;
        RegBackoffMin:     backoff_min     <= cfg_data;
        RegBackoffMax:     backoff_max     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      connected_flag   <= 1'b0;
      ever_connected   <= 1'b0;
      attempt_ticks    <= '0;
      retry_pending    <= 1'b0;
      retry_ticks_left <= '0;
      current_backoff  <= BackoffMinRst;
      in_valid         <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid        <= 1'b1;
        connected_flag   <= connected_flag_next;
        ever_connected   <= ever_connected_next;
        attempt_ticks    <= attempt_ticks_next;
        retry_pending    <= retry_pending_next;
        retry_ticks_left <= retry_ticks_left_next;
        current_backoff  <= current_backoff_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_assoc <= s_tdata[0];
    end
    if (advance) begin
      out_data <= {event_next, status_next, connected_flag_next, start_next};
    end
  end

endmodule

`default_nettype wire

/* tb/tb_link_reconnect_backoff_controller.sv */
// Self-checking testbench for the link reconnect backoff controller.
// It drives tick items, predicts each result from its own model of the supervisor and
// compares field by field. It depends on lrbc_pkg and link_reconnect_backoff_controller.
`default_nettype none

module tb_link_reconnect_backoff_controller;
  import lrbc_pkg::*;

  // Index 3 is not a register; writes to it must leave every setting alone.
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  // Cycles without any accepted item before the run is declared hung.
  localparam int unsigned StallLimit  = 2000;
  // Settling time after the last result is checked, before a register write.
  localparam int unsigned DrainCycles = 8;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // One expected result item, decoded into its fields.
  typedef struct {
    logic    start;
    logic    up;
    status_t status;
    event_t  ev;
  } tick_result_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata   = '0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [7:0]          m_tdata;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [RegWidth-1:0] cfg_data  = '0;

  link_reconnect_backoff_controller u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Ticks waiting to be driven, and results predicted but not yet seen.
  logic         tick_q[$];
  tick_result_t result_q[$];
  tick_result_t want;

  idle_mode_t  idle_mode = IDLE_NONE;
  int unsigned error_count   = 0;
  int unsigned checked_count = 0;
  int unsigned attempt_tally = 0;
  int unsigned phase_count   = 0;
  int unsigned event_tally[8];
  int unsigned quiet_cycles  = 0;

  // Our copy of the supervisor state and its three settings.
  logic                link_is_up;
  logic                was_ever_up;
  logic [15:0]         attempt_age;
  logic                retry_armed;
  logic [15:0]         retry_wait;
  logic [15:0]         backoff_now;
  logic [RegWidth-1:0] timeout_cfg;
  logic [RegWidth-1:0] min_cfg;
  logic [RegWidth-1:0] max_cfg;

  initial begin
    forever #5 clk = ~clk;
  end

  // Schedule a retry after the current delay, then double the delay up to the ceiling.
  // The doubled value needs a seventeenth bit so that large delays clamp correctly.
  task automatic arm_retry();
    logic [16:0] doubled;
    doubled     = {backoff_now, 1'b0};
    retry_armed = 1'b1;
    retry_wait  = backoff_now;
    backoff_now = (doubled < {1'b0, max_cfg}) ? doubled[15:0] : max_cfg;
  endtask

  // Advance the supervisor by one tick and queue the result it must produce.
  task automatic predict_tick(input logic assoc);
    tick_result_t r;
    r.start = 1'b0;
    r.ev    = EV_NONE;
    if (assoc) begin
      if (!link_is_up) begin
        r.ev        = was_ever_up ? EV_RECONNECTED : EV_CONNECTED;
        was_ever_up = 1'b1;
        link_is_up  = 1'b1;
        backoff_now = min_cfg;
        retry_armed = 1'b0;
        retry_wait  = '0;
      end
    end else if (link_is_up) begin
      r.ev       = EV_DISCONNECTED;
      link_is_up = 1'b0;
      arm_retry();
    end else if (retry_armed) begin
      // A delay of one (or zero) comes due on this tick and restarts the attempt.
      if (retry_wait <= 16'd1) begin
        retry_armed = 1'b0;
        retry_wait  = '0;
        attempt_age = '0;
        r.start     = 1'b1;
      end else begin
        retry_wait = retry_wait - 16'd1;
      end
    end else begin
      if (attempt_age != 16'hFFFF) attempt_age = attempt_age + 16'd1;
      if (attempt_age > timeout_cfg) begin
        r.ev = EV_TIMEOUT;
        arm_retry();
      end
    end
    r.up = link_is_up;
    if (link_is_up) r.status = ST_CONNECTED;
    else if (retry_armed) r.status = ST_DOWN;
    else r.status = ST_CONNECTING;
    result_q.push_back(r);
  endtask

  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(0, 99) < 58;
      IDLE_BOTH:   return $urandom_range(0, 99) < 22;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(0, 99) < 58;
      IDLE_BOTH:     return $urandom_range(0, 99) < 22;
      default:       return 1'b0;
    endcase
  endfunction

  // Driver: predicts each tick as it is accepted, then offers the next one. Valid is
  // assigned at most once per edge, so a held item never sees a low-high glitch.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) predict_tick(s_tdata[0]);
      if (!s_tvalid || s_tready) begin
        if (tick_q.size() != 0 && !sender_idles()) begin
          s_tdata  <= {7'd0, tick_q.pop_front()};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_val, act_val);
      error_count++;
    end
  endtask

  // Monitor: every accepted result is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual 0x%02h", $time, m_tdata);
          error_count++;
        end else begin
          want = result_q.pop_front();
          check_field("start_attempt", want.start, m_tdata[0]);
          check_field("link_up", want.up, m_tdata[1]);
          check_field("status", want.status, m_tdata[3:2]);
          check_field("event_res", want.ev, m_tdata[6:4]);
          check_field("zero fill", 0, m_tdata[7]);
          checked_count++;
          event_tally[m_tdata[6:4]]++;
          if (m_tdata[0]) attempt_tally++;
        end
      end
      m_tready <= !receiver_stalls();
    end
  end

  // Watchdog: a run that stops moving items for too long is hung.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no item moved for %0d cycles", $time, StallLimit);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Wait until every tick has been driven and every result checked, then let the
  // pipeline settle so that a register write lands on an idle block.
  task automatic wait_drained();
    do @(negedge clk); while (tick_q.size() != 0 || s_tvalid || result_q.size() != 0);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [RegWidth-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      RegAttemptTimeout: timeout_cfg = val;
      RegBackoffMin:     min_cfg     = val;
      RegBackoffMax:     max_cfg     = val;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [15:0] tmo, input logic [15:0] bmin,
                               input logic [15:0] bmax, input idle_mode_t mode);
    wait_drained();
    write_reg(RegAttemptTimeout, tmo);
    write_reg(RegBackoffMin, bmin);
    write_reg(RegBackoffMax, bmax);
    @(negedge clk);
    idle_mode = mode;
    phase_count++;
  endtask

  // Random phase. Most of the stimulus is alternating runs: long stretches without
  // association let attempts time out and retries come due, short associated runs
  // connect the link. Single random ticks are mixed in as noise. The span bounds the
  // length of an unassociated run and is picked to suit the phase's settings.
  task automatic run_phase(input logic [15:0] tmo, input logic [15:0] bmin,
                           input logic [15:0] bmax, input idle_mode_t mode,
                           input int unsigned n_ticks, input int unsigned span);
    int unsigned pushed;
    int unsigned run_len;
    logic        level;
    apply_setting(tmo, bmin, bmax, mode);
    pushed = 0;
    level  = 1'b0;
    while (pushed < n_ticks) begin
      if ($urandom_range(0, 99) < 15) begin
        tick_q.push_back(1'($urandom_range(0, 1)));
        pushed++;
      end else begin
        run_len = level ? $urandom_range(1, 6) : $urandom_range(1, span);
        repeat (run_len) tick_q.push_back(level);
        pushed += run_len;
        level = ~level;
      end
    end
  endtask

  initial begin
    link_is_up  = 1'b0;
    was_ever_up = 1'b0;
    attempt_age = '0;
    retry_armed = 1'b0;
    retry_wait  = '0;
    backoff_now = BackoffMinRst;
    timeout_cfg = TimeoutRst;
    min_cfg     = BackoffMinRst;
    max_cfg     = BackoffMaxRst;
    foreach (event_tally[i]) event_tally[i] = 0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: first connection, loss, association while a retry is pending,
    // reconnection and a repeated associated tick.
    @(negedge clk);
    phase_count++;
    tick_q.push_back(1'b1);
    tick_q.push_back(1'b0);
    tick_q.push_back(1'b0);
    tick_q.push_back(1'b1);
    tick_q.push_back(1'b1);
    tick_q.push_back(1'b0);
    tick_q.push_back(1'b1);
    tick_q.push_back(1'b0);

    // Tight settings: reconnect restores the minimum delay, a loss schedules a retry,
    // the retry comes due and starts an attempt, the attempt times out, the doubled
    // delay saturates at the ceiling, and association drops a pending retry.
    apply_setting(16'd3, 16'd2, 16'd5, IDLE_NONE);
    tick_q.push_back(1'b1);
    repeat (16) tick_q.push_back(1'b0);
    tick_q.push_back(1'b1);
    tick_q.push_back(1'b1);
    tick_q.push_back(1'b0);

    run_phase(16'd1, 16'd1, 16'd65535, IDLE_NONE, 175, 40);
    run_phase(16'd5, 16'd3, 16'd40, IDLE_SENDER, 175, 120);
    // Ceiling below the minimum: every doubled delay clamps to the ceiling.
    run_phase(16'd20, 16'd50, 16'd10, IDLE_RECEIVER, 175, 150);
    // Largest settings: only connection changes are reachable in a short phase.
    run_phase(16'd65534, 16'd65535, 16'd65535, IDLE_BOTH, 60, 10);
    // A write to the unused index; the settings below then rewrite all three registers.
    wait_drained();
    write_reg(RegUnused, 16'h5A5A);
    run_phase(16'd8, 16'd1, 16'd1, IDLE_BOTH, 175, 40);
    run_phase(16'd12, 16'd4, 16'd64, IDLE_RECEIVER, 175, 200);
    run_phase(16'd2, 16'd2, 16'd6, IDLE_SENDER, 175, 30);
    run_phase(TimeoutRst, BackoffMinRst, BackoffMaxRst, IDLE_NONE, 60, 20);

    wait_drained();

    $display("Checked %0d results over %0d settings, %0d attempts started.",
             checked_count, phase_count, attempt_tally);
    $display("Events: connected %0d, reconnected %0d, disconnected %0d, timeout %0d.",
             event_tally[EV_CONNECTED], event_tally[EV_RECONNECTED],
             event_tally[EV_DISCONNECTED], event_tally[EV_TIMEOUT]);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* link_reconnect_backoff_controller.f */
sv/lrbc_pkg.sv
sv/link_reconnect_backoff_controller.sv
tb/tb_link_reconnect_backoff_controller.sv
